// ===== hdl/window_stack_order_macros.svh =====
// assertion helpers for the window stack order rtl
`ifndef WINDOW_STACK_ORDER_MACROS_SVH
`define WINDOW_STACK_ORDER_MACROS_SVH

// property that must hold at every clock edge outside reset
`define WSO_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("window stack order check failed");

// consequence that must hold in the same cycle as its trigger
`define WSO_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("window stack order check failed");

// consequence that must hold in the cycle after its trigger
`define WSO_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("window stack order check failed");

`endif

// ===== hdl/wso_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wso_pkg
// Shared types and constants of the window stack order block: operation and
// status codes, request and response payloads, cell control word.
// ----------------------------------------------------------------------------
package wso_pkg;

  // default number of window slots
  localparam int SLOTS_DEFAULT = 12;
  // width of a slot number, depth or live count field
  localparam int SLOT_W = 4;

  typedef enum logic [1:0] {
    MODE_CREATE = 2'd0,
    MODE_CLOSE  = 2'd1,
    MODE_RAISE  = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_DEPTH     = 2'd3
  } status_t;

  // what every cell of the order list does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PUSH = 2'd1,   // take the upper neighbor, cell 0 takes the new value
    CELL_PULL = 2'd2    // take the lower neighbor
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [SLOT_W-1:0] pos;    // last cell that pushes, first cell that pulls
    logic [SLOT_W-1:0] value;  // entry written at the top on a push
  } cell_ctrl_t;

  typedef struct packed {
    mode_t             mode;
    logic [SLOT_W-1:0] start_slot;
    logic [SLOT_W-1:0] window_id;
    logic [SLOT_W-1:0] depth;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] live_count;
  } rsp_t;

endpackage

// ===== hdl/wso_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wso_cell
// One position of the front-to-back order list. Holds one slot number,
// shifts to or from its neighbors and flags a match against the window id.
// ----------------------------------------------------------------------------
module wso_cell #(
  parameter int SLOTS = wso_pkg::SLOTS_DEFAULT,
  parameter int IDX   = 0,
  parameter int CNT_W = $clog2(SLOTS + 1)
) (
  input  logic                       clk,
  input  wso_pkg::cell_ctrl_t        ctrl,
  input  logic [CNT_W-1:0]           count,
  input  logic [wso_pkg::SLOT_W-1:0] window_id,
  input  logic [wso_pkg::SLOT_W-1:0] upper,
  input  logic [wso_pkg::SLOT_W-1:0] lower,
  output logic [wso_pkg::SLOT_W-1:0] entry,
  output logic                       hit
);
  import wso_pkg::*;

  logic live;

  // live part of the list and match against the window id
  assign live = count > CNT_W'(IDX);
  assign hit  = live && (entry == window_id);

  // shift register stage of the list
  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_PUSH: begin
        if (IDX == 0) begin
          entry <= ctrl.value;
        end else if (ctrl.pos >= SLOT_W'(IDX)) begin
          entry <= upper;
        end
      end
      CELL_PULL: begin
        if (ctrl.pos <= SLOT_W'(IDX)) begin
          entry <= lower;
        end
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

endmodule

// ===== hdl/window_stack_order.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_stack_order
// Stacking-order manager for a fixed set of window slots: create, close,
// raise to top and read at depth over a move-to-front list of cells.
// ----------------------------------------------------------------------------
// Usage
//   req channel (req_valid / req_ready / req) carries one operation: mode,
//   start_slot, window_id and depth. rsp channel (rsp_valid / rsp_ready /
//   rsp) returns exactly one status, slot and live_count per operation.
//   The response sits in the output register in the cycle after the
//   request transfer. Throughput is one operation per cycle while the
//   receiver takes each response; each operation updates the whole cell
//   row at once, and the next one sees the new order.
//   req_ready is high whenever the output register is empty or being taken,
//   so a stalled receiver holds off new requests after one response waits.
//   Reset empties the list: no window open, live count zero, no response
//   pending. The order cells hold no meaningful value until written; only
//   entries below the live count are ever used.
// ----------------------------------------------------------------------------
`include "window_stack_order_macros.svh"

module window_stack_order #(
  parameter int SLOTS = wso_pkg::SLOTS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  wso_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output wso_pkg::rsp_t rsp
);
  import wso_pkg::*;

  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int SIDX_W = $clog2(SLOTS);
  localparam int CMP_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  logic                accept;
  logic [SLOTS-1:0]    occupied_map;
  logic [SLOTS-1:0]    occupied_map_next;
  logic [CNT_W-1:0]    open_count;
  logic [CNT_W-1:0]    open_count_next;
  logic [SLOT_W-1:0]   entry [SLOTS];
  logic [SLOTS-1:0]    hit;
  logic                found;
  logic [SLOT_W-1:0]   hit_pos;
  logic [SLOT_W-1:0]   mod_lut [2**SLOT_W];
  logic [SLOT_W-1:0]   start_mod;
  logic [SLOTS-1:0]    free_high;
  logic [SLOT_W-1:0]   free_slot;
  logic [SLOT_W-1:0]   free_high_slot;
  logic [SLOT_W-1:0]   free_low_slot;
  logic [SLOTS-1:0]    slot_bit;
  cell_ctrl_t          ctrl;
  rsp_t                rsp_next;

  assign accept    = req_valid && req_ready;
  assign req_ready = !rsp_valid || rsp_ready;

  // row of list cells, each fed by its neighbors
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic [SLOT_W-1:0] upper;
    logic [SLOT_W-1:0] lower;
    if (i == 0) begin : g_top
      assign upper = entry[i];
    end else begin : g_mid_up
      assign upper = entry[i-1];
    end
    if (i == SLOTS - 1) begin : g_bottom
      assign lower = entry[i];
    end else begin : g_mid_dn
      assign lower = entry[i+1];
    end
    wso_cell #(
      .SLOTS (SLOTS),
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (open_count),
      .window_id (req.window_id),
      .upper     (upper),
      .lower     (lower),
      .entry     (entry[i]),
      .hit       (hit[i])
    );
  end

  // position of the matching cell, hits are one-hot among live cells
  assign found = |hit;
  always_comb begin
    hit_pos = '0;
    for (int b = 0; b < SLOT_W; b++) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (((i >> b) & 1) == 1) begin
          hit_pos[b] = hit_pos[b] | hit[i];
        end
      end
    end
  end

  // start slot reduced modulo the slot count
  always_comb begin
    for (int i = 0; i < 2**SLOT_W; i++) begin
      mod_lut[i] = SLOT_W'(i % SLOTS);
    end
  end
  assign start_mod = mod_lut[req.start_slot];

  // first free slot at or after the start, wrapping to the lowest free
  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      free_high[j] = !occupied_map[j] && (SLOT_W'(j) >= start_mod);
    end
    free_high_slot = '0;
    free_low_slot  = '0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (free_high[j]) begin
        free_high_slot = SLOT_W'(j);
      end
      if (!occupied_map[j]) begin
        free_low_slot = SLOT_W'(j);
      end
    end
    free_slot = (|free_high) ? free_high_slot : free_low_slot;
  end

  // operation decode: response, cell control and map and count updates
  always_comb begin
    occupied_map_next = occupied_map;
    open_count_next   = open_count;
    ctrl.op           = CELL_HOLD;
    ctrl.pos          = '0;
    ctrl.value        = '0;
    rsp_next.status   = ST_OK;
    rsp_next.slot     = '0;
    slot_bit          = '0;
    unique case (req.mode)
      MODE_CREATE: begin
        if (open_count >= CNT_W'(SLOTS)) begin
          rsp_next.status = ST_FULL;
        end else begin
          slot_bit          = {{(SLOTS-1){1'b0}}, 1'b1} << free_slot;
          ctrl.op           = CELL_PUSH;
          ctrl.pos          = SLOT_W'(open_count);
          ctrl.value        = free_slot;
          occupied_map_next = occupied_map | slot_bit;
          open_count_next   = open_count + CNT_W'(1);
          rsp_next.slot     = free_slot;
        end
      end
      MODE_CLOSE, MODE_RAISE: begin
        rsp_next.slot = req.window_id;
        if (!found) begin
          rsp_next.status = ST_NOT_FOUND;
        end else if (req.mode == MODE_CLOSE) begin
          slot_bit          = {{(SLOTS-1){1'b0}}, 1'b1} << req.window_id;
          ctrl.op           = CELL_PULL;
          ctrl.pos          = hit_pos;
          occupied_map_next = occupied_map & ~slot_bit;
          open_count_next   = open_count - CNT_W'(1);
        end else begin
          ctrl.op    = CELL_PUSH;
          ctrl.pos   = hit_pos;
          ctrl.value = req.window_id;
        end
      end
      MODE_READ: begin
        if (CMP_W'(req.depth) >= CMP_W'(open_count)) begin
          rsp_next.status = ST_DEPTH;
        end else begin
          rsp_next.slot = entry[req.depth[SIDX_W-1:0]];
        end
      end
      default: begin
        rsp_next.status = ST_OK;
      end
    endcase
    rsp_next.live_count = SLOT_W'(open_count_next);
    if (!accept) begin
      ctrl.op = CELL_HOLD;
    end
  end

  // occupancy map and live count
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied_map <= '0;
      open_count   <= '0;
    end else if (accept) begin
      occupied_map <= occupied_map_next;
      open_count   <= open_count_next;
    end
  end

  // response register, one transfer per request
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // consistency checks
  `WSO_ASSERT_ALWAYS(a_count_matches_map, clk, rst, CNT_W'($countones(occupied_map)) == open_count)
  `WSO_ASSERT_ALWAYS(a_single_hit, clk, rst, $onehot0(hit))
  `WSO_ASSERT_ALWAYS(a_hit_matches_map, clk, rst, found == (((occupied_map >> req.window_id) & SLOTS'(1)) != '0))
  `WSO_ASSERT_NEXT(a_create_ok, clk, rst, accept && req.mode == MODE_CREATE && open_count < CNT_W'(SLOTS), rsp_valid && rsp.status == ST_OK)

endmodule
